// ===== design/tfpg_pkg.sv =====
// ----------------------------------------------------------------------------
// tfpg_pkg
// Shared types and constants for the three-finger gripper controller.
// ----------------------------------------------------------------------------
`default_nettype none

package tfpg_pkg;

  localparam int FingerCount = 3;
  localparam int WindowTicks = 100;
  localparam int PhaseW      = $clog2(WindowTicks);
  localparam int GoalTol     = 20;
  localparam int PosW        = 13;
  localparam int ErrW        = PosW + 1;
  localparam int ElW         = 16;
  localparam int LaneW       = 16;
  localparam int CfgW        = LaneW * FingerCount;
  localparam int SumW        = 40;
  localparam int AccW        = 64;
  localparam int MulAW       = 17;
  localparam int MulBW       = 26;
  localparam int ProdW       = MulAW + MulBW;
  localparam int MagW        = 30;
  localparam int DivW        = MagW + 32;
  localparam int DivCntW     = $clog2(DivW);
  localparam int RemW        = ElW + 1;
  localparam int RndShift    = 24;

  localparam logic [CfgW-1:0] OpenVelReset = 48'h07D0_07D0_07D0;
  localparam logic [PosW-1:0] ThrReset     = 13'd1;

  typedef enum logic [2:0] {
    REG_PROP_GAINS,
    REG_INTEG_GAINS,
    REG_DERIV_GAINS,
    REG_OPEN_VEL,
    REG_GOAL_POS,
    REG_FINGER_MODE,
    REG_USE_GOAL,
    REG_STALL_THR
  } cfg_reg_e;

  typedef enum logic [3:0] {
    L_IDLE, L_ES, L_SUM, L_IL, L_IH, L_D, L_DVI, L_DIV, L_ACC, L_RND
  } lane_state_e;

  typedef enum logic [1:0] {
    T_IDLE, T_RUN, T_FIN
  } top_state_e;

  typedef struct packed {
    logic            req_type;
    logic [PosW-1:0] finger_one_pos;
    logic [PosW-1:0] finger_two_pos;
    logic [PosW-1:0] finger_three_pos;
    logic [ElW-1:0]  elapsed_ticks;
  } in_t;

  typedef struct packed {
    logic signed [LaneW-1:0] finger_one_vel;
    logic signed [LaneW-1:0] finger_two_vel;
    logic signed [LaneW-1:0] finger_three_vel;
    logic                    grab_done;
  } out_t;

  typedef struct packed {
    logic                    go;
    logic                    grab;
    logic signed [ErrW-1:0]  err;
    logic [ElW-1:0]          el;
    logic signed [LaneW-1:0] kp;
    logic signed [LaneW-1:0] ki;
    logic signed [LaneW-1:0] kd;
  } lane_cmd_t;

  typedef struct packed {
    logic                    busy;
    logic signed [LaneW-1:0] vel;
  } lane_stat_t;

endpackage

`default_nettype wire

// ===== design/tfpg_lane.sv =====
// ----------------------------------------------------------------------------
// tfpg_lane
// One finger's PID drive: shared multiplier, saturating integrator and a
// bit-serial divider for the derivative term.
// ----------------------------------------------------------------------------
`default_nettype none

module tfpg_lane import tfpg_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire lane_cmd_t cmd_i,
  output lane_stat_t stat_o
);

  lane_state_e state_q, state_d;

  logic signed [ErrW-1:0]  e_q, prev_q;
  logic [ElW-1:0]          el_q;
  logic signed [LaneW-1:0] kp_q, ki_q, kd_q, vel_q;
  logic                    grab_q, neg_q;
  logic signed [SumW-1:0]  sum_q, s_q;
  logic signed [ProdW-1:0] prod_q;
  logic signed [AccW-1:0]  acc_q;
  logic [RemW-1:0]         rem_q;
  logic [DivW-1:0]         dvd_q;
  logic [DivCntW-1:0]      cnt_q;

  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [ProdW-1:0] prod;
  logic signed [ErrW:0]    diff;
  logic signed [SumW:0]    sum_ext;
  logic signed [SumW-1:0]  s_new;
  logic [ProdW-1:0]        mag;
  logic [RemW:0]           trial;
  logic                    qbit;
  logic signed [AccW-1:0]  rnd;
  logic signed [AccW-RndShift-1:0] rq;
  logic signed [LaneW-1:0] vel_sat;

  assign diff = (ErrW+1)'(e_q) - (ErrW+1)'(prev_q);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      L_ES: begin
        mul_a = MulAW'(e_q);
        mul_b = MulBW'(signed'({1'b0, el_q}));
      end
      L_SUM: begin
        mul_a = MulAW'(kp_q);
        mul_b = MulBW'(e_q);
      end
      L_IL: begin
        mul_a = MulAW'(ki_q);
        mul_b = MulBW'(signed'({1'b0, s_q[23:0]}));
      end
      L_IH: begin
        mul_a = MulAW'(ki_q);
        mul_b = MulBW'(signed'(s_q[SumW-1:24]));
      end
      L_D: begin
        mul_a = MulAW'(kd_q);
        mul_b = MulBW'(diff);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = ProdW'(mul_a) * ProdW'(mul_b);

  // integrator with 40-bit saturation
  always_comb begin
    sum_ext = (SumW+1)'(sum_q) + (SumW+1)'(prod_q);
    if (sum_ext[SumW] != sum_ext[SumW-1]) begin
      s_new = sum_ext[SumW] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
    end else begin
      s_new = sum_ext[SumW-1:0];
    end
  end

  assign mag   = prod_q[ProdW-1] ? ProdW'(-prod_q) : ProdW'(prod_q);
  assign trial = {rem_q, dvd_q[DivW-1]};
  assign qbit  = (trial >= (RemW+1)'(el_q));

  // round half up by 2^24, then clamp to 16 bits
  always_comb begin
    rnd = acc_q + AccW'(64'sd1 <<< (RndShift - 1));
    rq  = rnd[AccW-1:RndShift];
    if (rq > (AccW-RndShift)'(32767)) begin
      vel_sat = 16'sh7FFF;
    end else if (rq < -(AccW-RndShift)'(32768)) begin
      vel_sat = -16'sh8000;
    end else begin
      vel_sat = rq[LaneW-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      L_IDLE: if (cmd_i.go) state_d = L_ES;
      L_ES:   state_d = L_SUM;
      L_SUM:  state_d = L_IL;
      L_IL:   state_d = L_IH;
      L_IH:   state_d = L_D;
      L_D:    state_d = L_DVI;
      L_DVI:  state_d = (el_q == '0) ? L_RND : L_DIV;
      L_DIV:  if (cnt_q == DivCntW'(DivW - 1)) state_d = L_ACC;
      L_ACC:  state_d = L_RND;
      L_RND:  state_d = L_IDLE;
      default: state_d = L_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      sum_q   <= '0;
      prev_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == L_SUM && !grab_q) sum_q  <= s_new;
      if (state_q == L_D && !grab_q)   prev_q <= e_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod;
    unique case (state_q)
      L_IDLE: begin
        if (cmd_i.go) begin
          e_q    <= cmd_i.err;
          el_q   <= cmd_i.el;
          kp_q   <= cmd_i.kp;
          ki_q   <= cmd_i.ki;
          kd_q   <= cmd_i.kd;
          grab_q <= cmd_i.grab;
        end
      end
      L_SUM: s_q <= s_new;
      L_IL:  acc_q <= AccW'(prod_q) <<< 16;
      L_IH:  acc_q <= acc_q + AccW'(prod_q);
      L_D:   acc_q <= acc_q + (AccW'(prod_q) <<< 24);
      L_DVI: begin
        neg_q <= prod_q[ProdW-1];
        dvd_q <= {mag[MagW-1:0], 32'b0};
        rem_q <= '0;
        cnt_q <= '0;
      end
      L_DIV: begin
        rem_q <= qbit ? RemW'(trial - (RemW+1)'(el_q)) : trial[RemW-1:0];
        dvd_q <= {dvd_q[DivW-2:0], qbit};
        cnt_q <= cnt_q + DivCntW'(1);
      end
      L_ACC: begin
        acc_q <= neg_q ? acc_q - AccW'(dvd_q) : acc_q + AccW'(dvd_q);
      end
      L_RND: vel_q <= vel_sat;
      default: begin
      end
    endcase
  end

  assign stat_o.busy = (state_q != L_IDLE);
  assign stat_o.vel  = vel_q;

endmodule

`default_nettype wire

// ===== design/tfpg_merge.sv =====
// ----------------------------------------------------------------------------
// tfpg_merge
// Combines the lane drives, fixed grab velocities and done flag into one
// result word.
// ----------------------------------------------------------------------------
`default_nettype none

module tfpg_merge import tfpg_pkg::*; (
  input  wire lane_stat_t        stat_i [FingerCount],
  input  wire [CfgW-1:0]         open_vel_i,
  input  wire [FingerCount-1:0]  mode_i,
  input  wire                    done_tick_i,
  input  wire                    done_flag_i,
  output out_t                   word_o
);

  logic signed [LaneW-1:0] vel [FingerCount];

  always_comb begin
    for (int i = 0; i < FingerCount; i++) begin
      if (done_tick_i) begin
        vel[i] = '0;
      end else if (mode_i[i]) begin
        vel[i] = open_vel_i[LaneW*i +: LaneW];
      end else begin
        vel[i] = stat_i[i].vel;
      end
    end
  end

  assign word_o.finger_one_vel   = vel[0];
  assign word_o.finger_two_vel   = vel[1];
  assign word_o.finger_three_vel = vel[2];
  assign word_o.grab_done        = done_tick_i | done_flag_i;

endmodule

`default_nettype wire

// ===== design/three_finger_pid_gripper_unit.sv =====
// results: a start word gives no result; a tick word raises out_valid once
// every lane has finished, each running its 62-step derivative divider; the
// divider is skipped at zero elapsed time; no lane runs when the grab is done
// throughput: one word at a time, the next accepted the cycle after the result
// is staged
// reset: asynchronous, clears control state and loads register defaults
// ----------------------------------------------------------------------------
// three_finger_pid_gripper_unit
// Three-finger gripper controller: stall and goal checks up front, one PID
// lane per finger, merged into a velocity command word.
// ----------------------------------------------------------------------------
`default_nettype none

module three_finger_pid_gripper_unit import tfpg_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_ready_o,
  input  wire in_t   in_word_i,
  output logic       out_valid_o,
  input  wire        out_ready_i,
  output out_t       out_word_o,
  input  wire        cfg_valid_i,
  output logic       cfg_ready_o,
  input  wire [2:0]  cfg_index_i,
  input  wire [CfgW-1:0] cfg_data_i
);

  top_state_e state_q, state_d;

  logic [CfgW-1:0]        prop_q, integ_q, deriv_q, open_q, goal_q;
  logic [FingerCount-1:0] mode_q;
  logic                   use_goal_q;
  logic [PosW-1:0]        thr_q;

  logic [PosW-1:0]        ref_q [FingerCount];
  logic [PhaseW-1:0]      phase_q;
  logic                   passed_q, done_q;

  logic                   go_q, done_tick_q;
  logic signed [ErrW-1:0] err_q [FingerCount];
  logic [ElW-1:0]         el_q;
  logic                   out_valid_q;
  out_t                   out_word_q;

  logic [PosW-1:0]        pos [FingerCount];
  logic signed [ErrW-1:0] err [FingerCount];
  logic signed [ErrW-1:0] dpos;
  logic [ErrW-1:0]        adpos, aerr;
  logic                   stalled, at_goal, passed_nx, done_now;
  logic                   in_acc, tick_acc, start_acc, out_free, lanes_idle;
  logic [PhaseW-1:0]      phase_nx;

  lane_cmd_t  cmd  [FingerCount];
  lane_stat_t stat [FingerCount];
  out_t       merged;

  assign pos[0] = in_word_i.finger_one_pos;
  assign pos[1] = in_word_i.finger_two_pos;
  assign pos[2] = in_word_i.finger_three_pos;

  assign in_acc    = in_valid_i & in_ready_o;
  assign tick_acc  = in_acc & in_word_i.req_type;
  assign start_acc = in_acc & ~in_word_i.req_type;
  assign out_free  = ~out_valid_q | out_ready_i;
  assign cfg_ready_o = 1'b1;

  // stall check, then goal check which may zero errors
  always_comb begin
    stalled = 1'b1;
    at_goal = 1'b1;
    dpos    = '0;
    adpos   = '0;
    aerr    = '0;
    for (int i = 0; i < FingerCount; i++) begin
      err[i] = signed'({1'b0, goal_q[LaneW*i +: PosW]}) - signed'({1'b0, pos[i]});
      dpos   = signed'({1'b0, pos[i]}) - signed'({1'b0, ref_q[i]});
      adpos  = dpos[ErrW-1] ? ErrW'(-dpos) : ErrW'(dpos);
      if (mode_q[i] && !(adpos < {1'b0, thr_q})) stalled = 1'b0;
    end
    for (int i = 0; i < FingerCount; i++) begin
      aerr = err[i][ErrW-1] ? ErrW'(-err[i]) : ErrW'(err[i]);
      if (stalled && use_goal_q && !mode_q[i]) begin
        if (aerr < ErrW'(GoalTol)) err[i] = '0;
        else at_goal = 1'b0;
      end
    end
    passed_nx = passed_q | (phase_q == '0);
    done_now  = stalled & at_goal & passed_nx;
    phase_nx  = (phase_q == PhaseW'(WindowTicks - 1)) ? '0 : phase_q + PhaseW'(1);
  end

  always_comb begin
    lanes_idle = ~go_q;
    for (int i = 0; i < FingerCount; i++) begin
      if (stat[i].busy) lanes_idle = 1'b0;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      T_IDLE: if (tick_acc) state_d = T_RUN;
      T_RUN:  if (lanes_idle) state_d = T_FIN;
      T_FIN:  if (out_free) state_d = T_IDLE;
      default: state_d = T_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == T_IDLE);
  end

  for (genvar g = 0; g < FingerCount; g++) begin : g_lane
    assign cmd[g].go   = go_q;
    assign cmd[g].grab = mode_q[g];
    assign cmd[g].err  = err_q[g];
    assign cmd[g].el   = el_q;
    assign cmd[g].kp   = prop_q[LaneW*g +: LaneW];
    assign cmd[g].ki   = integ_q[LaneW*g +: LaneW];
    assign cmd[g].kd   = deriv_q[LaneW*g +: LaneW];

    tfpg_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cmd[g]),
      .stat_o (stat[g])
    );
  end

  tfpg_merge u_merge (
    .stat_i      (stat),
    .open_vel_i  (open_q),
    .mode_i      (mode_q),
    .done_tick_i (done_tick_q),
    .done_flag_i (done_q),
    .word_o      (merged)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      prop_q      <= '0;
      integ_q     <= '0;
      deriv_q     <= '0;
      open_q      <= OpenVelReset;
      goal_q      <= '0;
      mode_q      <= '0;
      use_goal_q  <= 1'b0;
      thr_q       <= ThrReset;
      for (int i = 0; i < FingerCount; i++) ref_q[i] <= '0;
      phase_q     <= PhaseW'(1);
      passed_q    <= 1'b0;
      done_q      <= 1'b0;
      go_q        <= 1'b0;
      done_tick_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      go_q    <= 1'b0;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_reg_e'(cfg_index_i))
          REG_PROP_GAINS:  prop_q     <= cfg_data_i;
          REG_INTEG_GAINS: integ_q    <= cfg_data_i;
          REG_DERIV_GAINS: deriv_q    <= cfg_data_i;
          REG_OPEN_VEL:    open_q     <= cfg_data_i;
          REG_GOAL_POS:    goal_q     <= cfg_data_i;
          REG_FINGER_MODE: mode_q     <= cfg_data_i[FingerCount-1:0];
          REG_USE_GOAL:    use_goal_q <= cfg_data_i[0];
          REG_STALL_THR:   thr_q      <= cfg_data_i[PosW-1:0];
          default: begin
          end
        endcase
      end
      if (start_acc) begin
        for (int i = 0; i < FingerCount; i++) ref_q[i] <= pos[i];
        phase_q  <= PhaseW'(1);
        passed_q <= 1'b0;
        done_q   <= 1'b0;
      end
      if (tick_acc) begin
        if (phase_q == '0) begin
          for (int i = 0; i < FingerCount; i++) ref_q[i] <= pos[i];
        end
        phase_q     <= phase_nx;
        passed_q    <= passed_nx;
        if (done_now) done_q <= 1'b1;
        done_tick_q <= done_now;
        go_q        <= ~done_now;
      end
      if (state_q == T_FIN && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_acc) begin
      for (int i = 0; i < FingerCount; i++) err_q[i] <= err[i];
      el_q <= in_word_i.elapsed_ticks;
    end
    if (state_q == T_FIN && out_free) out_word_q <= merged;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  a_idle_lanes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == T_IDLE) |-> (!stat[0].busy && !stat[1].busy && !stat[2].busy))
    else $error("lane busy while controller idle");

  a_go_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go_q |-> (state_q == T_RUN))
    else $error("lane launch outside run state");

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q < PhaseW'(WindowTicks))
    else $error("window phase out of range");

  a_done_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == T_FIN && done_tick_q) |-> (merged.finger_one_vel == '0 && merged.grab_done))
    else $error("done result carries drive");

endmodule

`default_nettype wire
